>>> rtl/scd_pkg.sv
// shared constants and codes of the scaled column texel drawer
package scd_pkg;

	localparam int TEXEL_COUNT   = 64;
	localparam int SHADE_ENTRIES = 256;
	localparam int ADDR_BITS     = 24;

	localparam int TEX_BITS    = $clog2(TEXEL_COUNT);
	localparam int SHADE_BITS  = $clog2(SHADE_ENTRIES);
	localparam int PIX_BITS    = 8;
	localparam int HEIGHT_BITS = 14;
	localparam int COL_BITS    = 12;
	localparam int WIDTH_BITS  = 12;
	localparam int CROW_BITS   = 11;
	localparam int SCALE_BITS  = 5;
	localparam int CFG_BITS    = 24;

	// 6.16 step, 2^21 / height needs 22 bits
	localparam int FRAC_BITS  = 16;
	localparam int STEP_BITS  = FRAC_BITS + TEX_BITS;
	localparam int DIV_STEPS  = STEP_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

	// texel indexes of the two halves around the middle of the column
	localparam int TEX_MID = TEXEL_COUNT / 2;

	localparam logic [1:0] CMD_LOAD_TEXEL = 2'd0;
	localparam logic [1:0] CMD_LOAD_SHADE = 2'd1;
	localparam logic [1:0] CMD_START_POST = 2'd2;
	localparam logic [1:0] CMD_DRAW_ROW   = 2'd3;

	localparam logic [1:0] REG_FRAME_BASE   = 2'd0;
	localparam logic [1:0] REG_SCREEN_WIDTH = 2'd1;
	localparam logic [1:0] REG_CENTER_ROW   = 2'd2;
	localparam logic [1:0] REG_SCALE_FACTOR = 2'd3;

	localparam logic [ADDR_BITS-1:0]  RST_FRAME_BASE   = '0;
	localparam logic [WIDTH_BITS-1:0] RST_SCREEN_WIDTH = WIDTH_BITS'(320);
	localparam logic [CROW_BITS-1:0]  RST_CENTER_ROW   = CROW_BITS'(72);
	localparam logic [SCALE_BITS-1:0] RST_SCALE_FACTOR = SCALE_BITS'(1);

endpackage

>>> rtl/scd_channels.sv
// valid/ready channel interfaces of the scaled column texel drawer
interface scd_cmd_if import scd_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             command;
	logic [TEX_BITS-1:0]    texel_slot;
	logic [SHADE_BITS-1:0]  shade_slot;
	logic [PIX_BITS-1:0]    load_value;
	logic [HEIGHT_BITS-1:0] post_height;
	logic [COL_BITS-1:0]    column_x;
	logic                   lighted;

	modport source (output valid, command, texel_slot, shade_slot, load_value,
		post_height, column_x, lighted, input ready);
	modport sink (input valid, command, texel_slot, shade_slot, load_value,
		post_height, column_x, lighted, output ready);
endinterface

interface scd_pix_if import scd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] write_address;
	logic [PIX_BITS-1:0]  pixel_value;
	logic                 write_valid;
	logic                 post_done;
	logic                 last_of_run;

	modport source (output valid, write_address, pixel_value, write_valid, post_done,
		last_of_run, input ready);
	modport sink (input valid, write_address, pixel_value, write_valid, post_done,
		last_of_run, output ready);
endinterface

interface scd_cfg_if import scd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          index;
	logic [CFG_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/scd_ram.sv
// generic simple dual-port ram with registered read
module scd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/scaled_column_texel_drawer.sv
// top level: wall post scaler with texel column, shading table and row sequencer
//
//   channel  dir  handshake          payload
//   cmd_ch   in   valid/ready        command, slots, load_value, post_height, column_x, lighted
//   pix_ch   out  valid/ready        write_address, pixel_value, write_valid, post_done,
//                                    last_of_run
//   cfg_ch   in   valid/ready (=1)   index, data
//
// sequence: a load or a start of height 0 completes in idle; a start of nonzero height
// runs the shared multiplier for the clamp product, then the bit-serial restoring divider
// for the step; a draw with rows left runs two halves of texel read, shade read and address
// add, one multiplier pass each; a draw past the end returns one empty result. output
// stalls hold a draw in its result state while the result register is full.
// reset: async active low; config returns to its defaults, post state clears, the
// texel and shade rams are not cleared.
// the result register lets the sequencer return to idle while the last result waits.
module scaled_column_texel_drawer import scd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	scd_cmd_if.sink   cmd_ch,
	scd_pix_if.source pix_ch,
	scd_cfg_if.sink   cfg_ch
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LIM,
		ST_DIV,
		ST_TEX,
		ST_SHD,
		ST_PIX,
		ST_NULL
	} state_t;

	state_t state_q;

	// configuration registers
	logic [ADDR_BITS-1:0]  base_q;
	logic [WIDTH_BITS-1:0] width_q;
	logic [CROW_BITS-1:0]  crow_q;
	logic [SCALE_BITS-1:0] scale_q;

	// post state
	logic [STEP_BITS-1:0]   step_q;
	logic [STEP_BITS-1:0]   acc_q;
	logic [HEIGHT_BITS-1:0] row_cnt_q;
	logic [HEIGHT_BITS-1:0] row_lim_q;
	logic [COL_BITS-1:0]    col_q;
	logic                   shade_on_q;

	// divider and sequencer working registers
	logic [HEIGHT_BITS-1:0]  h_q;
	logic [HEIGHT_BITS-1:0]  rem_q;
	logic [STEP_BITS-1:0]    quo_q;
	logic [DIV_CNT_BITS-1:0] div_cnt_q;
	logic                    half_q;
	logic [ADDR_BITS-1:0]    prod_q;
	logic [ADDR_BITS-1:0]    addr_q;
	logic [PIX_BITS-1:0]     texel_q;

	// result register
	logic                 out_valid_q;
	logic [ADDR_BITS-1:0] out_addr_q;
	logic [PIX_BITS-1:0]  out_pix_q;
	logic                 out_wr_q;
	logic                 out_done_q;
	logic                 out_last_q;

	logic cmd_fire;
	logic out_free;
	logic out_load;
	logic rows_left;
	logic last_row;

	logic [TEX_BITS-1:0]   tex_pos;
	logic [TEX_BITS-1:0]   tex_raddr;
	logic [PIX_BITS-1:0]   tex_rdata;
	logic [PIX_BITS-1:0]   shade_rdata;
	logic                  tex_we;
	logic                  shade_we;
	logic                  tex_re;
	logic                  shade_re;

	logic [ADDR_BITS-1:0]            row_top;
	logic [ADDR_BITS-1:0]            row_bot;
	logic [ADDR_BITS-1:0]            mul_a;
	logic [WIDTH_BITS-1:0]           mul_b;
	logic [ADDR_BITS+WIDTH_BITS-1:0] mul_full;

	logic [HEIGHT_BITS:0]  div_trial;
	logic                  div_ge;
	logic [HEIGHT_BITS:0]  div_diff;
	logic [STEP_BITS-1:0]  quo_next;

	assign cmd_ch.ready = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign cmd_fire     = cmd_ch.valid && cmd_ch.ready;
	assign out_free     = !out_valid_q || pix_ch.ready;
	// a new result enters the output register this cycle
	assign out_load     = ((state_q == ST_PIX) || (state_q == ST_NULL)) && out_free;

	assign rows_left = row_cnt_q < row_lim_q;
	assign last_row  = ({1'b0, row_cnt_q} + (HEIGHT_BITS+1)'(1)) >= {1'b0, row_lim_q};

	// texel position from the integer part of the accumulator
	assign tex_pos   = acc_q[FRAC_BITS +: TEX_BITS];
	assign tex_raddr = half_q ? (TEX_BITS'(TEX_MID) + tex_pos)
		: (TEX_BITS'(TEX_MID - 1) - tex_pos);

	// row numbers wrap modulo the address width
	assign row_top = ADDR_BITS'(crow_q) - ADDR_BITS'(row_cnt_q) - ADDR_BITS'(1);
	assign row_bot = ADDR_BITS'(crow_q) + ADDR_BITS'(row_cnt_q);

	// shared multiplier: clamp product on start, row offset on draw
	always_comb begin
		if (state_q == ST_LIM) begin
			mul_a = ADDR_BITS'(crow_q);
			mul_b = WIDTH_BITS'(scale_q);
		end else begin
			mul_a = half_q ? row_bot : row_top;
			mul_b = width_q;
		end
	end
	assign mul_full = {{WIDTH_BITS{1'b0}}, mul_a} * {{ADDR_BITS{1'b0}}, mul_b};

	// restoring division of 2^21 by the height, one quotient bit per cycle
	assign div_trial = {rem_q, (div_cnt_q == '0)};
	assign div_ge    = div_trial >= {1'b0, h_q};
	assign div_diff  = div_trial - {1'b0, h_q};
	assign quo_next  = {quo_q[STEP_BITS-2:0], div_ge};

	assign tex_we   = cmd_fire && (cmd_ch.command == CMD_LOAD_TEXEL);
	assign shade_we = cmd_fire && (cmd_ch.command == CMD_LOAD_SHADE);
	assign tex_re   = (state_q == ST_TEX);
	assign shade_re = (state_q == ST_SHD);

	scd_ram #(
		.WIDTH(PIX_BITS),
		.DEPTH(TEXEL_COUNT)
	) u_texel_ram (
		.clk  (clk),
		.we   (tex_we),
		.waddr(cmd_ch.texel_slot),
		.wdata(cmd_ch.load_value),
		.re   (tex_re),
		.raddr(tex_raddr),
		.rdata(tex_rdata)
	);

	scd_ram #(
		.WIDTH(PIX_BITS),
		.DEPTH(SHADE_ENTRIES)
	) u_shade_ram (
		.clk  (clk),
		.we   (shade_we),
		.waddr(cmd_ch.shade_slot),
		.wdata(cmd_ch.load_value),
		.re   (shade_re),
		.raddr(SHADE_BITS'(tex_rdata)),
		.rdata(shade_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= RST_FRAME_BASE;
			width_q     <= RST_SCREEN_WIDTH;
			crow_q      <= RST_CENTER_ROW;
			scale_q     <= RST_SCALE_FACTOR;
			step_q      <= '0;
			acc_q       <= '0;
			row_cnt_q   <= '0;
			row_lim_q   <= '0;
			col_q       <= '0;
			shade_on_q  <= 1'b0;
			h_q         <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			div_cnt_q   <= '0;
			half_q      <= 1'b0;
			prod_q      <= '0;
			addr_q      <= '0;
			texel_q     <= '0;
			out_valid_q <= 1'b0;
			out_addr_q  <= '0;
			out_pix_q   <= '0;
			out_wr_q    <= 1'b0;
			out_done_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (pix_ch.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_ch.valid) begin
				unique case (cfg_ch.index)
					REG_FRAME_BASE:   base_q  <= ADDR_BITS'(cfg_ch.data);
					REG_SCREEN_WIDTH: width_q <= cfg_ch.data[WIDTH_BITS-1:0];
					REG_CENTER_ROW:   crow_q  <= cfg_ch.data[CROW_BITS-1:0];
					REG_SCALE_FACTOR: scale_q <= cfg_ch.data[SCALE_BITS-1:0];
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						unique case (cmd_ch.command)
							CMD_LOAD_TEXEL, CMD_LOAD_SHADE: begin
								state_q <= ST_IDLE;
							end
							CMD_START_POST: begin
								col_q      <= cmd_ch.column_x;
								shade_on_q <= cmd_ch.lighted;
								row_cnt_q  <= '0;
								h_q        <= cmd_ch.post_height;
								if (cmd_ch.post_height == '0) begin
									step_q    <= '0;
									acc_q     <= '0;
									row_lim_q <= '0;
								end else begin
									state_q <= ST_LIM;
								end
							end
							CMD_DRAW_ROW: begin
								half_q  <= 1'b0;
								state_q <= rows_left ? ST_TEX : ST_NULL;
							end
						endcase
					end
				end
				ST_LIM: begin
					// clamp product center_row * scale_factor
					prod_q    <= mul_full[ADDR_BITS-1:0];
					rem_q     <= '0;
					quo_q     <= '0;
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						row_lim_q <= (ADDR_BITS'(h_q) > prod_q) ? HEIGHT_BITS'(crow_q) : h_q;
					end
					rem_q <= div_ge ? div_diff[HEIGHT_BITS-1:0] : div_trial[HEIGHT_BITS-1:0];
					quo_q <= quo_next;
					if (div_cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
						step_q  <= quo_next;
						acc_q   <= quo_next >> 1;
						state_q <= ST_IDLE;
					end else begin
						div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
					end
				end
				ST_TEX: begin
					// texel read issued, row offset through the multiplier
					prod_q  <= mul_full[ADDR_BITS-1:0];
					state_q <= ST_SHD;
				end
				ST_SHD: begin
					// shade read issued with the texel just read
					texel_q <= tex_rdata;
					addr_q  <= base_q + prod_q + ADDR_BITS'(col_q);
					state_q <= ST_PIX;
				end
				ST_PIX: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_addr_q  <= addr_q;
						out_pix_q   <= shade_on_q ? shade_rdata : texel_q;
						out_wr_q    <= 1'b1;
						out_done_q  <= last_row;
						out_last_q  <= half_q;
						if (half_q) begin
							row_cnt_q <= row_cnt_q + HEIGHT_BITS'(1);
							acc_q     <= acc_q + step_q;
							half_q    <= 1'b0;
							state_q   <= ST_IDLE;
						end else begin
							half_q  <= 1'b1;
							state_q <= ST_TEX;
						end
					end
				end
				ST_NULL: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_addr_q  <= '0;
						out_pix_q   <= '0;
						out_wr_q    <= 1'b0;
						out_done_q  <= 1'b1;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign pix_ch.valid         = out_valid_q;
	assign pix_ch.write_address = out_addr_q;
	assign pix_ch.pixel_value   = out_pix_q;
	assign pix_ch.write_valid   = out_wr_q;
	assign pix_ch.post_done     = out_done_q;
	assign pix_ch.last_of_run   = out_last_q;

	// the row counter never runs past the latched limit
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_cnt_q <= row_lim_q)
		else $error("row counter beyond row limit");

	// a result without a pixel write always closes the post and the run
	a_null_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_wr_q |-> out_done_q && out_last_q)
		else $error("empty result without done and last");

	// a waiting top write means the sequencer is on the bottom half
	a_top_then_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_wr_q && !out_last_q |-> half_q)
		else $error("top write pending outside bottom half");

	// a nonzero start leaves idle for the clamp and divide sequence
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && cmd_ch.command == CMD_START_POST && cmd_ch.post_height != '0
		|=> state_q == ST_LIM)
		else $error("start did not enter the divide sequence");

	// while the divider stays busy, its step count has moved past zero
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && $past(state_q) == ST_DIV |-> div_cnt_q != '0)
		else $error("divider step count lost");

endmodule
